// File: rtl/sst_pkg.sv
// sst_pkg: shared types and constants of the sparse triplet table
// item and result structs, controller/datapath command and status structs
// no dependencies
package sst_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 9'd6;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 9'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       search;
    logic       shift;
    logic       write_key;
    logic       finish;
    logic [1:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_bad;
    logic is_read;
    logic srch_done;
    logic srch_hit;
    logic full;
    logic shift_done;
  } stat_t;

endpackage

// File: rtl/sst_ram.sv
// sst_ram: generic single write port, single read port ram with registered read
// depends on nothing
module sst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/sst_datapath.sv
// sst_datapath: key registers, config registers, triplet ram, scan and shift pointers
// depends on sst_pkg and sst_ram
module sst_datapath import sst_pkg::*; #(
  parameter int CAPACITY    = 128,
  parameter int INDEX_WIDTH = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  in_item_t               request,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   done,
  output out_item_t              result
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int EW    = 2 * INDEX_WIDTH + VALUE_WIDTH;
  localparam int CMP_W = (INDEX_WIDTH > CFG_DATA_W) ? INDEX_WIDTH : CFG_DATA_W;

  logic                   key_op;
  logic [INDEX_WIDTH-1:0] key_row;
  logic [INDEX_WIDTH-1:0] key_col;
  logic [VALUE_WIDTH-1:0] key_value;
  logic [CFG_DATA_W-1:0]  rows_in_use;
  logic [CFG_DATA_W-1:0]  cols_in_use;
  logic [CW-1:0]          count;
  logic [CW-1:0]          ptr;
  logic [CW-1:0]          ptr_dec;
  logic [CW-1:0]          chk_idx;
  logic                   chk_vld;
  logic [CW-1:0]          pos;
  logic                   hit;
  logic [VALUE_WIDTH-1:0] found_value;
  logic                   wr_pend;
  logic [AW-1:0]          wr_addr;

  logic                   ram_we;
  logic [AW-1:0]          ram_wr_addr;
  logic [EW-1:0]          ram_wr_data;
  logic [AW-1:0]          ram_rd_addr;
  logic [EW-1:0]          ram_rd_data;

  logic [INDEX_WIDTH-1:0] e_row;
  logic [INDEX_WIDTH-1:0] e_col;
  logic [VALUE_WIDTH-1:0] e_val;
  logic                   e_ge;
  logic                   e_eq;
  logic                   at_end;
  logic                   shift_issue;
  logic                   rv_ok;

  sst_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign e_row = ram_rd_data[EW-1 -: INDEX_WIDTH];
  assign e_col = ram_rd_data[VALUE_WIDTH +: INDEX_WIDTH];
  assign e_val = ram_rd_data[VALUE_WIDTH-1:0];

  // row-major order: first entry not below the key ends the scan
  assign e_ge   = (e_row > key_row) || ((e_row == key_row) && (e_col >= key_col));
  assign e_eq   = (e_row == key_row) && (e_col == key_col);
  assign at_end = (chk_idx == count);

  assign ptr_dec     = ptr - CW'(1);
  assign shift_issue = cmd.shift && (ptr != pos);

  assign ram_rd_addr = cmd.search ? ptr[AW-1:0] : ptr_dec[AW-1:0];

  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = wr_addr;
    ram_wr_data = ram_rd_data;
    if (wr_pend) begin
      ram_we = 1'b1;
    end else if (cmd.write_key) begin
      ram_we      = 1'b1;
      ram_wr_addr = pos[AW-1:0];
      ram_wr_data = {key_row, key_col, key_value};
    end
  end

  always_comb begin
    stat.range_bad  = (CMP_W'(key_row) >= CMP_W'(rows_in_use)) ||
                      (CMP_W'(key_col) >= CMP_W'(cols_in_use));
    stat.is_read    = (key_op == OP_READ);
    stat.srch_done  = chk_vld && (at_end || e_ge);
    stat.srch_hit   = chk_vld && !at_end && e_eq;
    stat.full       = (count == CW'(CAPACITY));
    stat.shift_done = (ptr == pos) && !wr_pend;
  end

  assign rv_ok = (key_op == OP_READ) && hit && (cmd.status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
      count       <= '0;
      chk_vld     <= 1'b0;
      wr_pend     <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS: rows_in_use <= cfg_data;
          REG_COLS: cols_in_use <= cfg_data;
          default:  ;
        endcase
      end

      if (cmd.load) begin
        chk_vld <= 1'b0;
      end else if (cmd.search) begin
        chk_vld <= 1'b1;
      end

      // one ram read in flight per shift step, written one place higher next cycle
      wr_pend <= shift_issue;

      if (cmd.write_key && !hit) begin
        count <= count + CW'(1);
      end

      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_op    <= request.operation;
      key_row   <= INDEX_WIDTH'(request.row);
      key_col   <= INDEX_WIDTH'(request.col);
      key_value <= VALUE_WIDTH'($unsigned(request.value));
      ptr       <= '0;
      hit       <= 1'b0;
    end else if (cmd.search) begin
      chk_idx <= ptr;
      if (stat.srch_done) begin
        pos         <= chk_idx;
        hit         <= stat.srch_hit;
        found_value <= e_val;
        ptr         <= count;
      end else begin
        ptr <= ptr + CW'(1);
      end
    end else if (shift_issue) begin
      ptr     <= ptr_dec;
      wr_addr <= ptr[AW-1:0];
    end

    if (cmd.finish) begin
      result.status      <= cmd.status;
      result.read_value  <= rv_ok ? 32'(found_value) : '0;
      result.entry_count <= 8'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ($past(cmd.write_key && !hit) && (count == $past(count) + CW'(1))))
    else $error("entry count changed outside an insert");

  a_shift_write: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(cmd.shift))
    else $error("shift write without a shift step");

endmodule

// File: rtl/sst_ctrl.sv
// sst_ctrl: sequencer for one item: search, optional shift, optional write, result
// depends on sst_pkg
module sst_ctrl import sst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_WRITE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] item_status;
  logic [1:0] item_status_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    item_status_next = item_status;
    cmd              = '0;
    cmd.status       = item_status;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load         = 1'b1;
          item_status_next = ST_OK;
          state_next       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.range_bad) begin
          item_status_next = ST_RANGE;
          state_next       = S_FINISH;
        end else if (stat.srch_done) begin
          if (stat.is_read) begin
            state_next = S_FINISH;
          end else if (stat.srch_hit) begin
            state_next = S_WRITE;
          end else if (stat.full) begin
            item_status_next = ST_FULL;
            state_next       = S_FINISH;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_key = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      item_status <= ST_OK;
    end else begin
      state       <= state_next;
      item_status <= item_status_next;
    end
  end

  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.search, cmd.shift, cmd.write_key, cmd.finish}))
    else $error("more than one datapath command at once");

  a_write_then_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.write_key |=> cmd.finish)
    else $error("table write not followed by result");

  a_finish_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !busy)
    else $error("still busy after result");

endmodule

// File: rtl/sparse_triplet_table.sv
// sparse_triplet_table: sorted (row, col, value) triplet list with lookup and insert
// a read, a replace or a refused item needs no shift step; an insert scans, then shifts the
// stored entries up one place (scan then shift, one ram entry per cycle)
// one item at a time; busy stays high until the cycle the result is presented
// done is a one-cycle strobe and the result cannot be held off by the receiver
// synchronous reset empties the table and sets rows_in_use 6, cols_in_use 7
module sparse_triplet_table import sst_pkg::*; #(
  parameter int CAPACITY    = 128,
  parameter int INDEX_WIDTH = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               request,
  output logic                   done,
  output out_item_t              result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  sst_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  sst_datapath #(
    .CAPACITY   (CAPACITY),
    .INDEX_WIDTH(INDEX_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .request  (request),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .result   (result)
  );

endmodule
